// ===== rtl/stkpp_pkg.sv =====
// Shared constants, codes and types of the spectral top-K peak picker.
package stkpp_pkg;

   // Parameter defaults
   localparam int unsigned MAX_PEAKS_DEF = 8;
   localparam int unsigned BINS_DEF      = 1024;
   localparam int unsigned MAG_WIDTH_DEF = 32;

   // Fixed field widths of the channels
   localparam int unsigned MAG_W     = 32;
   localparam int unsigned BIN_W     = 10;
   localparam int unsigned RANK_W    = 3;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned CFG_W     = 10;
   localparam int unsigned CSR_IDX_W = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LO_BIN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HI_BIN = CSR_IDX_W'(1);

   // Register reset values
   localparam logic [CFG_W-1:0] LO_BIN_RST = CFG_W'(1);
   localparam logic [CFG_W-1:0] HI_BIN_RST = CFG_W'(1022);

   typedef enum logic [0:0] {
      ST_RUN,
      ST_EMIT
   } stkpp_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic step;    // one input beat accepted
      logic load;    // load the result register from the list
      logic clear;   // empty the list after the last result
   } stkpp_cmd_type;

endpackage

// ===== rtl/stkpp_if.sv =====
// Channel interfaces: input beat, result beat and register write.
interface stkpp_req_if import stkpp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude;
   logic             frame_end;

   modport source (output valid, output magnitude, output frame_end, input ready);
   modport sink   (input valid, input magnitude, input frame_end, output ready);
endinterface

interface stkpp_rsp_if import stkpp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BIN_W-1:0]   peak_bin;
   logic [MAG_W-1:0]   peak_magnitude;
   logic [RANK_W-1:0]  peak_rank;
   logic [COUNT_W-1:0] found_count;
   logic               no_peak;
   logic               last_result;

   modport source (output valid, output peak_bin, output peak_magnitude, output peak_rank,
                   output found_count, output no_peak, output last_result, input ready);
   modport sink   (input valid, input peak_bin, input peak_magnitude, input peak_rank,
                   input found_count, input no_peak, input last_result, output ready);
endinterface

interface stkpp_csr_if import stkpp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/stkpp_ctrl.sv =====
// Controller: run/emit state machine, result valid and emit index.
module stkpp_ctrl import stkpp_pkg::*; #(
   parameter int unsigned MAX_PEAKS = MAX_PEAKS_DEF,
   localparam int unsigned IDX_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_frame_end,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stkpp_cmd_type    cmd,
   output logic [IDX_W-1:0] emit_idx,
   input  logic             emit_last
);

   stkpp_state_type  state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign emit_idx  = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            req_ready = 1'b1;
            cmd.step  = req_valid;
            if (req_valid && req_frame_end) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (emit_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_RUN;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
      endcase
   end

   a_end_starts_emit: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_frame_end |=> state_ff == ST_EMIT)
      else $error("frame end beat did not start emission");

   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && out_free && emit_last |=> state_ff == ST_RUN && rsp_valid_ff)
      else $error("last result did not return to run");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      32'(idx_ff) < MAX_PEAKS)
      else $error("emit index beyond list");

endmodule

// ===== rtl/stkpp_dp.sv =====
// Datapath: bin window, peak test, sorted top-K list and result register.
module stkpp_dp import stkpp_pkg::*; #(
   parameter int unsigned MAX_PEAKS = MAX_PEAKS_DEF,
   parameter int unsigned BINS      = BINS_DEF,
   parameter int unsigned MAG_WIDTH = MAG_WIDTH_DEF,
   localparam int unsigned IDX_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic [MAG_W-1:0]     in_magnitude,
   input  logic                 in_frame_end,
   input  stkpp_cmd_type        cmd,
   input  logic [IDX_W-1:0]     emit_idx,
   output logic                 emit_last,
   output logic [BIN_W-1:0]     out_bin,
   output logic [MAG_W-1:0]     out_magnitude,
   output logic [RANK_W-1:0]    out_rank,
   output logic [COUNT_W-1:0]   out_count,
   output logic                 out_no_peak,
   output logic                 out_last
);

   localparam int unsigned CNT_W = $clog2(BINS);
   localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int unsigned PK_W  = $clog2(MAX_PEAKS + 1);
   localparam int unsigned SUM_W = PK_W + 1;

   logic [CFG_W-1:0]     lo_bin_ff, hi_bin_ff;
   logic [MAG_WIDTH-1:0] left_ff, centre_ff;
   logic [CNT_W-1:0]     bin_cnt_ff;
   logic [PK_W-1:0]      count_ff;
   logic [CNT_W-1:0]     list_bin_ff [MAX_PEAKS];
   logic [MAG_WIDTH-1:0] list_mag_ff [MAX_PEAKS];
   logic [CNT_W-1:0]     list_bin_in [MAX_PEAKS];
   logic [MAG_WIDTH-1:0] list_mag_in [MAX_PEAKS];
   logic [MAX_PEAKS-1:0] keep, prev_keep;

   logic [MAG_WIDTH-1:0] mag;
   logic [CNT_W-1:0]     centre_bin;
   logic [CMP_W-1:0]     centre_x;
   logic                 is_peak, full, ins;

   assign mag        = MAG_WIDTH'(in_magnitude);
   assign centre_bin = bin_cnt_ff - CNT_W'(1);
   assign centre_x   = CMP_W'(centre_bin);

   // Peak test on the previous bin, with the arriving bin as right neighbor
   assign is_peak = (bin_cnt_ff >= CNT_W'(2))
                 && (centre_x >= CMP_W'(lo_bin_ff))
                 && (centre_x <= CMP_W'(hi_bin_ff))
                 && (centre_ff > left_ff)
                 && (centre_ff >= mag);

   assign full = (count_ff == PK_W'(MAX_PEAKS));
   assign ins  = is_peak && (!full || (centre_ff > list_mag_ff[MAX_PEAKS-1]));

   // Parallel insert: entries at or above the new peak hold, the slot below
   // the last of them takes the peak, the rest shift down one place.
   always_comb begin
      for (int i = 0; i < MAX_PEAKS; i++) begin
         keep[i] = (SUM_W'(i) < SUM_W'(count_ff)) && (list_mag_ff[i] >= centre_ff);
      end
      prev_keep[0] = 1'b1;
      for (int i = 1; i < MAX_PEAKS; i++) begin
         prev_keep[i] = keep[i-1];
      end
      for (int i = 0; i < MAX_PEAKS; i++) begin
         if (keep[i]) begin
            list_bin_in[i] = list_bin_ff[i];
            list_mag_in[i] = list_mag_ff[i];
         end else if (prev_keep[i]) begin
            list_bin_in[i] = centre_bin;
            list_mag_in[i] = centre_ff;
         end else begin
            list_bin_in[i] = list_bin_ff[(i > 0) ? i - 1 : 0];
            list_mag_in[i] = list_mag_ff[(i > 0) ? i - 1 : 0];
         end
      end
   end

   assign emit_last = (count_ff == '0)
                   || (SUM_W'(emit_idx) + SUM_W'(1) == SUM_W'(count_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_bin_ff <= LO_BIN_RST;
         hi_bin_ff <= HI_BIN_RST;
      end else if (csr_we) begin
         if (csr_idx == CSR_LO_BIN) begin
            lo_bin_ff <= csr_data;
         end else if (csr_idx == CSR_HI_BIN) begin
            hi_bin_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= '0;
         centre_ff  <= '0;
         bin_cnt_ff <= '0;
      end else if (cmd.step) begin
         if (in_frame_end) begin
            left_ff    <= '0;
            centre_ff  <= '0;
            bin_cnt_ff <= '0;
         end else begin
            left_ff   <= centre_ff;
            centre_ff <= mag;
            if (bin_cnt_ff < CNT_W'(BINS - 1)) begin
               bin_cnt_ff <= bin_cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.step && ins && !full) begin
         count_ff <= count_ff + PK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && ins) begin
         list_bin_ff <= list_bin_in;
         list_mag_ff <= list_mag_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (count_ff == '0) begin
            out_bin       <= '0;
            out_magnitude <= '0;
            out_rank      <= '0;
            out_count     <= '0;
            out_no_peak   <= 1'b1;
            out_last      <= 1'b1;
         end else begin
            out_bin       <= BIN_W'(list_bin_ff[emit_idx]);
            out_magnitude <= MAG_W'(list_mag_ff[emit_idx]);
            out_rank      <= RANK_W'(emit_idx);
            out_count     <= COUNT_W'(count_ff);
            out_no_peak   <= 1'b0;
            out_last      <= emit_last;
         end
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_PEAKS)
      else $error("list count beyond capacity");

   a_bin_sat: assert property (@(posedge clock) disable iff (reset)
      32'(bin_cnt_ff) <= BINS - 1)
      else $error("bin counter past saturation");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.step && ins && !full && !cmd.clear |=> count_ff == $past(count_ff) + PK_W'(1))
      else $error("insert into open list did not grow count");

endmodule

// ===== rtl/spectral_top_k_peak_picker.sv =====
// Top level of the spectral top-K peak picker.
// Usage:
//  - req_bus carries one spectrum magnitude per beat, bin 0 first; frame_end
//    marks the last bin of a frame. A bin in [lo_bin, hi_bin] is a peak
//    when strictly above its left neighbor and not below its right one; it is
//    tested when the next bin arrives.
//  - Outside a frame end the block takes one beat per cycle; the peak test and
//    the compare-and-shift insertion into the sorted list finish in that cycle.
//  - On a frame_end beat req_ready drops while the list is sent on rsp_bus,
//    strongest first, one result per cycle; an empty frame yields one result
//    with no_peak set. The frame_end beat moves the controller to its emit
//    state, which then loads the first result into the result register.
//  - rsp_bus has a result register: a stall of the receiver holds it and
//    pauses emission; after the last result is loaded the next frame's beats
//    are accepted while it still waits to be taken.
//  - csr_bus writes lo_bin (index 0) and hi_bin (index 1), always ready;
//    write only while no frame is in flight.
//  - Synchronous reset clears control state, the bin window and the list
//    count, and sets lo_bin to 1 and hi_bin to 1022.
module spectral_top_k_peak_picker import stkpp_pkg::*; #(
   parameter int unsigned MAX_PEAKS = MAX_PEAKS_DEF,
   parameter int unsigned BINS      = BINS_DEF,
   parameter int unsigned MAG_WIDTH = MAG_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   stkpp_req_if.sink   req_bus,
   stkpp_rsp_if.source rsp_bus,
   stkpp_csr_if.sink   csr_bus
);

   localparam int unsigned IDX_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;

   stkpp_cmd_type    cmd;
   logic [IDX_W-1:0] emit_idx;
   logic             emit_last;

   // Registers are plain flops; a write is never stalled.
   assign csr_bus.ready = 1'b1;

   stkpp_ctrl #(
      .MAX_PEAKS (MAX_PEAKS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_frame_end (req_bus.frame_end),
      .req_ready     (req_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .cmd           (cmd),
      .emit_idx      (emit_idx),
      .emit_last     (emit_last)
   );

   stkpp_dp #(
      .MAX_PEAKS (MAX_PEAKS),
      .BINS      (BINS),
      .MAG_WIDTH (MAG_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_bus.valid),
      .csr_idx       (csr_bus.index),
      .csr_data      (csr_bus.data),
      .in_magnitude  (req_bus.magnitude),
      .in_frame_end  (req_bus.frame_end),
      .cmd           (cmd),
      .emit_idx      (emit_idx),
      .emit_last     (emit_last),
      .out_bin       (rsp_bus.peak_bin),
      .out_magnitude (rsp_bus.peak_magnitude),
      .out_rank      (rsp_bus.peak_rank),
      .out_count     (rsp_bus.found_count),
      .out_no_peak   (rsp_bus.no_peak),
      .out_last      (rsp_bus.last_result)
   );

endmodule
